[rtl/bts_pkg.sv]
// Shared constants, types and helpers for the bilinear texture sampler.
package bts_pkg;

    localparam int COORD_BITS  = 16;
    localparam int WEIGHT_BITS = 8;
    localparam int SIDE_BITS   = 9;
    localparam int IDX_BITS    = 8;
    localparam int ADDR_BITS   = 16;
    localparam int TEXEL_BITS  = 32;
    localparam int LANE_BITS   = 8;
    localparam int LANES       = TEXEL_BITS / LANE_BITS;
    localparam int SCALED_BITS = COORD_BITS + SIDE_BITS;
    localparam int K_BITS      = 2 * WEIGHT_BITS + 1;
    localparam int TEX_DEPTH   = 65536;
    localparam int MAX_SIDE    = 256;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [IDX_BITS-1:0]    lo;
        logic [IDX_BITS-1:0]    hi;
        logic [WEIGHT_BITS-1:0] wt;
    } loc_t;

    // Map a programmed side length onto 1..MAX_SIDE.
    function automatic logic [SIDE_BITS-1:0] clamp_side(input logic [SIDE_BITS-1:0] s);
        logic [SIDE_BITS-1:0] r;
        r = s;
        if (s == '0)
            r = SIDE_BITS'(1);
        else if (s > SIDE_BITS'(MAX_SIDE))
            r = SIDE_BITS'(MAX_SIDE);
        return r;
    endfunction

endpackage

[rtl/bts_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[rtl/bts_locate.sv]
// Coordinate unit: scale a wrapped fraction to texel space, find neighbours and weight.
module bts_locate (
    input  logic                            clk,
    input  logic                            load,
    input  logic                            en,
    input  logic [bts_pkg::COORD_BITS-1:0]  coord,
    input  logic [bts_pkg::SIDE_BITS-1:0]   side,
    output bts_pkg::loc_t                   loc
);

    localparam logic [bts_pkg::SCALED_BITS-1:0] HALF =
        bts_pkg::SCALED_BITS'(1) << (bts_pkg::COORD_BITS - 1);

    logic [bts_pkg::SCALED_BITS-1:0] scaled_reg;
    logic [bts_pkg::SIDE_BITS-1:0]   side_reg;
    logic [bts_pkg::SCALED_BITS-1:0] pos;
    logic [bts_pkg::COORD_BITS-1:0]  frac;
    logic [bts_pkg::SIDE_BITS-1:0]   base;
    logic [bts_pkg::SIDE_BITS-1:0]   base_up;
    logic [bts_pkg::SIDE_BITS-1:0]   last;
    bts_pkg::loc_t                   loc_next;
    bts_pkg::loc_t                   loc_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= bts_pkg::SCALED_BITS'(coord * side);
            side_reg   <= side;
        end
        if (en)
        begin
            loc_reg <= loc_next;
        end
    end

    always_comb
    begin
        last = side_reg - bts_pkg::SIDE_BITS'(1);
        pos  = scaled_reg - HALF;
        if (scaled_reg < HALF)
        begin
            // left/bottom of the first texel center: both neighbours are index 0
            base    = '0;
            base_up = '0;
            frac    = bts_pkg::COORD_BITS'(scaled_reg + HALF);
        end
        else
        begin
            base    = bts_pkg::SIDE_BITS'(pos[bts_pkg::SCALED_BITS-2:bts_pkg::COORD_BITS]);
            base_up = base + bts_pkg::SIDE_BITS'(1);
            frac    = pos[bts_pkg::COORD_BITS-1:0];
        end
        loc_next.lo = bts_pkg::IDX_BITS'((base > last) ? last : base);
        loc_next.hi = bts_pkg::IDX_BITS'((base_up > last) ? last : base_up);
        loc_next.wt = frac[bts_pkg::COORD_BITS-1 -: bts_pkg::WEIGHT_BITS];
    end

    assign loc = loc_reg;

endmodule

[rtl/bts_blend.sv]
// Per-lane weighted blend of four texels with truncation and saturation.
module bts_blend (
    input  logic [bts_pkg::TEXEL_BITS-1:0] t00,
    input  logic [bts_pkg::TEXEL_BITS-1:0] t10,
    input  logic [bts_pkg::TEXEL_BITS-1:0] t01,
    input  logic [bts_pkg::TEXEL_BITS-1:0] t11,
    input  logic [bts_pkg::K_BITS-1:0]     k00,
    input  logic [bts_pkg::K_BITS-1:0]     k10,
    input  logic [bts_pkg::K_BITS-1:0]     k01,
    input  logic [bts_pkg::K_BITS-1:0]     k11,
    output logic [bts_pkg::TEXEL_BITS-1:0] texel
);

    localparam int SUM_BITS = bts_pkg::K_BITS + bts_pkg::LANE_BITS + 2;
    localparam int SHIFT    = 2 * bts_pkg::WEIGHT_BITS;

    logic [SUM_BITS-1:0] sum [bts_pkg::LANES];
    logic [SUM_BITS-1:0] lane_val [bts_pkg::LANES];

    always_comb
    begin
        for (int l = 0; l < bts_pkg::LANES; l++)
        begin
            sum[l] = SUM_BITS'(t00[l*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS] * k00)
                   + SUM_BITS'(t10[l*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS] * k10)
                   + SUM_BITS'(t01[l*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS] * k01)
                   + SUM_BITS'(t11[l*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS] * k11);
            lane_val[l] = sum[l] >> SHIFT;
            if (lane_val[l] > SUM_BITS'(255))
                texel[l*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS] = 8'hFF;
            else
                texel[l*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS] =
                    lane_val[l][bts_pkg::LANE_BITS-1:0];
        end
    end

endmodule

[rtl/bilinear_texture_sampler.sv]
// Top level of the bilinear texture sampler: pipeline, texture memory and output register.
// A write transaction (func 0) stores one 32-bit texel; a sample transaction (func 1)
// fetches its four neighbours as two pairs, lower row then upper row, through the two
// read ports of the 65536-entry texture memory. A sample passes through the stage 1,
// stage 2, issue, read-return and output registers in that order. Texel contents are
// undefined until written; never sample a texel that was not written. Program
// tex_width and tex_height only while no transaction is in flight.
module bilinear_texture_sampler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic                            cfg_index,
    input  logic [bts_pkg::SIDE_BITS-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [bts_pkg::ADDR_BITS-1:0]   texel_index,
    input  logic [bts_pkg::TEXEL_BITS-1:0]  texel_value,
    input  logic [bts_pkg::COORD_BITS-1:0]  coord_u,
    input  logic [bts_pkg::COORD_BITS-1:0]  coord_v,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bts_pkg::TEXEL_BITS-1:0]  filtered_texel
);

    localparam logic [bts_pkg::SIDE_BITS-1:0] SCALE =
        bts_pkg::SIDE_BITS'(1) << bts_pkg::WEIGHT_BITS;

    // configuration
    logic [bts_pkg::SIDE_BITS-1:0] tex_width_reg;
    logic [bts_pkg::SIDE_BITS-1:0] tex_height_reg;
    logic [bts_pkg::SIDE_BITS-1:0] w_side;
    logic [bts_pkg::SIDE_BITS-1:0] h_side;

    // pipeline control
    logic adv;
    logic en_up;

    // stage 1: scaling multiply
    logic                           s1_valid_reg;
    logic                           s1_func_reg;
    logic [bts_pkg::ADDR_BITS-1:0]  s1_idx_reg;
    logic [bts_pkg::TEXEL_BITS-1:0] s1_value_reg;

    // stage 2: neighbours and weights
    logic                           s2_valid_reg;
    logic                           s2_func_reg;
    logic [bts_pkg::ADDR_BITS-1:0]  s2_idx_reg;
    logic [bts_pkg::TEXEL_BITS-1:0] s2_value_reg;
    bts_pkg::loc_t                  loc_x;
    bts_pkg::loc_t                  loc_y;

    // address and blend-weight products
    logic [bts_pkg::IDX_BITS-1:0]   row0;
    logic [bts_pkg::IDX_BITS-1:0]   row1;
    logic [bts_pkg::SIDE_BITS-1:0]  wx_inv;
    logic [bts_pkg::SIDE_BITS-1:0]  wy_inv;

    // stage 4: memory issue
    logic                           s4_valid_reg;
    logic                           s4_func_reg;
    logic                           s4_phase_reg;
    logic [bts_pkg::TEXEL_BITS-1:0] s4_value_reg;
    logic [bts_pkg::ADDR_BITS-1:0]  a00_reg, a10_reg, a01_reg, a11_reg;
    logic [bts_pkg::K_BITS-1:0]     k00_reg, k10_reg, k01_reg, k11_reg;

    // stage 5: memory data return
    logic                           rd_valid_reg;
    logic                           rd_phase_reg;
    logic [bts_pkg::K_BITS-1:0]     rk00_reg, rk10_reg, rk01_reg, rk11_reg;
    logic [bts_pkg::TEXEL_BITS-1:0] t00_reg, t10_reg;
    logic [bts_pkg::TEXEL_BITS-1:0] rdata_a, rdata_b;

    // memory ports
    logic                           ram_we;
    logic [bts_pkg::ADDR_BITS-1:0]  ram_raddr_a;
    logic [bts_pkg::ADDR_BITS-1:0]  ram_raddr_b;

    // output
    logic                           out_valid_reg;
    logic [bts_pkg::TEXEL_BITS-1:0] out_data_reg;
    logic [bts_pkg::TEXEL_BITS-1:0] blend_texel;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= bts_pkg::SIDE_BITS'(1);
            tex_height_reg <= bts_pkg::SIDE_BITS'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                bts_pkg::REG_WIDTH:  tex_width_reg  <= cfg_data;
                bts_pkg::REG_HEIGHT: tex_height_reg <= cfg_data;
            endcase
        end
    end

    assign w_side = bts_pkg::clamp_side(tex_width_reg);
    assign h_side = bts_pkg::clamp_side(tex_height_reg);

    // Advance whenever the output register is free or being drained.
    // Hold the front end while a sample is in its lower-row issue phase.
    assign adv      = !out_valid_reg || out_ready;
    assign en_up    = adv && !(s4_valid_reg && (s4_func_reg == bts_pkg::FUNC_SAMPLE)
                               && !s4_phase_reg);
    assign in_ready = en_up || !s1_valid_reg;

    bts_locate u_loc_x (
        .clk   (clk),
        .load  (in_ready),
        .en    (en_up),
        .coord (coord_u),
        .side  (w_side),
        .loc   (loc_x)
    );

    bts_locate u_loc_y (
        .clk   (clk),
        .load  (in_ready),
        .en    (en_up),
        .coord (coord_v),
        .side  (h_side),
        .loc   (loc_y)
    );

    // Front-end valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en_up)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Front-end payload.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_func_reg  <= func;
            s1_idx_reg   <= texel_index;
            s1_value_reg <= texel_value;
        end
        if (en_up)
        begin
            s2_func_reg  <= s1_func_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_value_reg <= s1_value_reg;
        end
    end

    // Rows are stored bottom-up: flip against the height.
    assign row0   = bts_pkg::IDX_BITS'(h_side - bts_pkg::SIDE_BITS'(1)
                                       - bts_pkg::SIDE_BITS'(loc_y.lo));
    assign row1   = bts_pkg::IDX_BITS'(h_side - bts_pkg::SIDE_BITS'(1)
                                       - bts_pkg::SIDE_BITS'(loc_y.hi));
    assign wx_inv = SCALE - bts_pkg::SIDE_BITS'(loc_x.wt);
    assign wy_inv = SCALE - bts_pkg::SIDE_BITS'(loc_y.wt);

    // Issue stage: a sample stays for phase 0, the lower row, and then phase 1, the upper row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s4_phase_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (s4_valid_reg && (s4_func_reg == bts_pkg::FUNC_SAMPLE) && !s4_phase_reg)
            begin
                s4_phase_reg <= 1'b1;
            end
            else
            begin
                s4_valid_reg <= s2_valid_reg;
                s4_phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_up)
        begin
            s4_func_reg  <= s2_func_reg;
            s4_value_reg <= s2_value_reg;
            // Writes reuse the first address slot; a sample address wraps at the store depth.
            if (s2_func_reg == bts_pkg::FUNC_WRITE)
                a00_reg <= s2_idx_reg;
            else
                a00_reg <= bts_pkg::ADDR_BITS'(row0 * w_side + bts_pkg::ADDR_BITS'(loc_x.lo));
            a10_reg <= bts_pkg::ADDR_BITS'(row0 * w_side + bts_pkg::ADDR_BITS'(loc_x.hi));
            a01_reg <= bts_pkg::ADDR_BITS'(row1 * w_side + bts_pkg::ADDR_BITS'(loc_x.lo));
            a11_reg <= bts_pkg::ADDR_BITS'(row1 * w_side + bts_pkg::ADDR_BITS'(loc_x.hi));
            k00_reg <= bts_pkg::K_BITS'(wx_inv * wy_inv);
            k10_reg <= bts_pkg::K_BITS'(loc_x.wt * wy_inv);
            k01_reg <= bts_pkg::K_BITS'(wx_inv * loc_y.wt);
            k11_reg <= bts_pkg::K_BITS'(loc_x.wt * loc_y.wt);
        end
    end

    // A write issues once, in the cycle it leaves the issue stage; later samples read after it.
    assign ram_we      = adv && s4_valid_reg && (s4_func_reg == bts_pkg::FUNC_WRITE);
    assign ram_raddr_a = s4_phase_reg ? a01_reg : a00_reg;
    assign ram_raddr_b = s4_phase_reg ? a11_reg : a10_reg;

    bts_ram #(
        .WIDTH (bts_pkg::TEXEL_BITS),
        .DEPTH (bts_pkg::TEX_DEPTH)
    ) u_tex_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (a00_reg),
        .wdata   (s4_value_reg),
        .re      (adv),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Read-return tag: which half of a sample the memory data holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_phase_reg <= 1'b0;
        end
        else if (adv)
        begin
            rd_valid_reg <= s4_valid_reg && (s4_func_reg == bts_pkg::FUNC_SAMPLE);
            rd_phase_reg <= s4_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rk00_reg <= k00_reg;
            rk10_reg <= k10_reg;
            rk01_reg <= k01_reg;
            rk11_reg <= k11_reg;
            // Park the lower-row pair while the upper-row pair is fetched.
            if (rd_valid_reg && !rd_phase_reg)
            begin
                t00_reg <= rdata_a;
                t10_reg <= rdata_b;
            end
        end
    end

    bts_blend u_blend (
        .t00   (t00_reg),
        .t10   (t10_reg),
        .t01   (rdata_a),
        .t11   (rdata_b),
        .k00   (rk00_reg),
        .k10   (rk10_reg),
        .k01   (rk01_reg),
        .k11   (rk11_reg),
        .texel (blend_texel)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= rd_valid_reg && rd_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= blend_texel;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_texel = out_data_reg;

    // The upper-row pair always follows the lower-row pair on the next advance.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && rd_valid_reg && !rd_phase_reg) |=> (rd_valid_reg && rd_phase_reg))
        else $error("upper-row read did not follow lower-row read");

    // A texel write never issues in the second half of a sample.
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !s4_phase_reg)
        else $error("texel write issued during sample upper-row read");

    // A result appears only one advance after an upper-row return.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(rd_valid_reg && rd_phase_reg))
        else $error("result without a completed sample");

endmodule

[test/tb.sv]
// Testbench for the bilinear texture sampler: random writes and samples checked against a model.

class filter_scoreboard;
    bit [31:0] texels [int];       // texture memory contents seen so far
    bit [8:0]  width_reg = 9'd1;
    bit [8:0]  height_reg = 9'd1;
    bit [31:0] pending_texels [$];
    int        mismatches;
    int        samples_checked;

    function int side_of(bit [8:0] s);
        if (s == 0)
            return 1;
        if (s > bts_pkg::MAX_SIDE)
            return bts_pkg::MAX_SIDE;
        return s;
    endfunction

    function void locate(bit [15:0] c, int n, output int lo, output int hi, output int wt);
        int scaled;
        int base;
        int frac;
        scaled = c * n;
        if (scaled < 32768)
        begin
            base = -1;
            frac = scaled + 32768;
        end
        else
        begin
            base = (scaled - 32768) >> 16;
            frac = (scaled - 32768) & 16'hFFFF;
        end
        lo = (base < 0) ? 0 : ((base > n - 1) ? n - 1 : base);
        hi = (base + 1 > n - 1) ? n - 1 : base + 1;
        wt = frac >> 8;
    endfunction

    // Return the four store addresses a sample touches: 00, 10, 01, 11.
    function void neighbor_addrs(bit [15:0] u, bit [15:0] v, output int a [4], output int wx,
                                 output int wy);
        int w;
        int h;
        int x0;
        int x1;
        int y0;
        int y1;
        w = side_of(width_reg);
        h = side_of(height_reg);
        locate(u, w, x0, x1, wx);
        locate(v, h, y0, y1, wy);
        a[0] = ((h - 1 - y0) * w + x0) & 16'hFFFF;
        a[1] = ((h - 1 - y0) * w + x1) & 16'hFFFF;
        a[2] = ((h - 1 - y1) * w + x0) & 16'hFFFF;
        a[3] = ((h - 1 - y1) * w + x1) & 16'hFFFF;
    endfunction

    function bit is_written(int a);
        return texels.exists(a);
    endfunction

    function void note_input(bit fn, bit [15:0] idx, bit [31:0] val, bit [15:0] u,
                             bit [15:0] v);
        int a [4];
        int wx;
        int wy;
        int k [4];
        bit [31:0] t [4];
        bit [31:0] res;
        longint sum;
        if (fn == bts_pkg::FUNC_WRITE)
        begin
            texels[idx] = val;
            return;
        end
        neighbor_addrs(u, v, a, wx, wy);
        foreach (t[i])
            t[i] = texels.exists(a[i]) ? texels[a[i]] : 32'h0;
        k[0] = (256 - wx) * (256 - wy);
        k[1] = wx * (256 - wy);
        k[2] = (256 - wx) * wy;
        k[3] = wx * wy;
        res = 0;
        for (int lane = 0; lane < 4; lane++)
        begin
            sum = 0;
            for (int i = 0; i < 4; i++)
                sum += longint'(t[i][lane*8 +: 8]) * k[i];
            sum = sum >> 16;
            if (sum > 255)
                sum = 255;
            res[lane*8 +: 8] = sum[7:0];
        end
        pending_texels.push_back(res);
    endfunction

    function void check_result(bit [31:0] got);
        bit [31:0] want;
        if (pending_texels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = pending_texels.pop_front();
        samples_checked++;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("filtered_texel mismatch: expected %h, got %h", want, got);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [15:0] texel_index;
    logic [31:0] texel_value;
    logic [15:0] coord_u;
    logic [15:0] coord_v;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] filtered_texel;

    filter_scoreboard sb = new();

    bit quiet;             // no idling on either side in the last phase
    int hold_cycles;       // long receiver hold-off, counted down by the receiver
    int idle_cycles;
    int items_sent;

    bilinear_texture_sampler uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .texel_index(texel_index), .texel_value(texel_value),
        .coord_u(coord_u), .coord_v(coord_v),
        .out_valid(out_valid), .out_ready(out_ready), .filtered_texel(filtered_texel)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: check each result transaction, stall in short random bursts,
    // and honor a long hold-off when one is requested.
    int stall_left;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(filtered_texel);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which no transaction moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("watchdog expired, %0d results outstanding", sb.pending_texels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one transaction, optionally after a short idle burst; hold it until accepted.
    task automatic push(bit fn, bit [15:0] idx, bit [31:0] val, bit [15:0] u, bit [15:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= fn;
        texel_index <= idx;
        texel_value <= val;
        coord_u     <= u;
        coord_v     <= v;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_input(fn, idx, val, u, v);
        items_sent++;
    endtask

    // Sample at (u, v), writing any neighbor texel not yet stored first.
    task automatic sample_at(bit [15:0] u, bit [15:0] v);
        int a [4];
        int wx;
        int wy;
        sb.neighbor_addrs(u, v, a, wx, wy);
        foreach (a[i])
            if (!sb.is_written(a[i]))
                push(bts_pkg::FUNC_WRITE, 16'(a[i]), $urandom, 16'($urandom), 16'($urandom));
        push(bts_pkg::FUNC_SAMPLE, 16'($urandom), $urandom, u, v);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_texels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.width_reg  = (idx == bts_pkg::REG_WIDTH)  ? data : sb.width_reg;
        sb.height_reg = (idx == bts_pkg::REG_HEIGHT) ? data : sb.height_reg;
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                push(bts_pkg::FUNC_WRITE, 16'($urandom), $urandom, 16'($urandom),
                     16'($urandom));
            else
                sample_at(16'($urandom), 16'($urandom));
        end
    endtask

    int sizes [7][2] = '{'{4, 3}, '{1, 1}, '{256, 256}, '{0, 5}, '{300, 2},
                         '{7, 256}, '{16, 16}};

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = 1'b0;
        texel_index = '0;
        texel_value = '0;
        coord_u = '0;
        coord_v = '0;
        out_ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (sizes[p])
        begin
            quiet = (p == 6);
            write_reg(bts_pkg::REG_WIDTH, 9'(sizes[p][0]));
            write_reg(bts_pkg::REG_HEIGHT, 9'(sizes[p][1]));
            if (p == 0)
            begin
                // Directed: extreme texels, corners, edges and exact texel centers.
                push(bts_pkg::FUNC_WRITE, 16'hFFFF, 32'hFFFFFFFF, 16'h0, 16'h0);
                push(bts_pkg::FUNC_WRITE, 16'h0000, 32'h00000000, 16'hFFFF, 16'hFFFF);
                sample_at(16'h0000, 16'h0000);
                sample_at(16'hFFFF, 16'hFFFF);
                sample_at(16'h0000, 16'hFFFF);
                sample_at(16'hFFFF, 16'h0000);
                sample_at(16'h2000, 16'h2AAA);
                sample_at(16'h8000, 16'h8000);
                sample_at(16'h1FFF, 16'h2AAB);
                push(bts_pkg::FUNC_WRITE, 16'h0005, 32'hFFFFFFFF, 16'h0, 16'h0);
                sample_at(16'h6000, 16'h5555);
            end
            if (p == 2)
            begin
                // Hold the receiver off while the sender keeps offering samples.
                hold_cycles = 300;
                random_phase(40);
            end
            random_phase(35);
            drain();
        end

        $display("%0d transactions sent, %0d samples checked over %0d texture sizes",
                 items_sent, sb.samples_checked, 7);
        $display("sizes covered the 1x1 and 256x256 extremes plus out-of-range widths");
        if (sb.mismatches == 0 && sb.pending_texels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
